>>> hdl/pncs_pkg.sv
// Shared types and constants for the palette nearest-color search block.
package pncs_pkg;

  localparam int CMD_W       = 2;
  localparam int CH_W        = 8;
  localparam int PAL_W       = 3 * CH_W;
  localparam int SUM_W       = CH_W + 2;
  localparam int DIST_W      = CH_W + 2;
  localparam int AVG_TAPS    = 4;
  localparam int AVG_K_W     = 2;
  localparam int ENTRIES_DEF = 256;

  localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_FIND = 2'd1;
  localparam logic [CMD_W-1:0] CMD_AVG  = 2'd2;

  typedef struct packed {
    logic wr_en;
    logic capture;
    logic avg_rd;
    logic avg_commit;
    logic scan_rd;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic cnt_last;
    logic avg_last;
    logic pipe_idle;
  } ctrl_sts_t;

endpackage

>>> hdl/pncs_dp.sv
// Datapath: palette memory, averaging accumulators, distance pipeline and best tracker.
module pncs_dp #(
  parameter int PALETTE_ENTRIES = pncs_pkg::ENTRIES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pncs_pkg::ctrl_cmd_t       cmd,
  output pncs_pkg::ctrl_sts_t       sts,
  input  logic [pncs_pkg::CH_W-1:0] in_entry_index,
  input  logic [pncs_pkg::CH_W-1:0] in_red,
  input  logic [pncs_pkg::CH_W-1:0] in_green,
  input  logic [pncs_pkg::CH_W-1:0] in_blue,
  input  logic [pncs_pkg::CH_W-1:0] in_index_top_left,
  input  logic [pncs_pkg::CH_W-1:0] in_index_top_right,
  input  logic [pncs_pkg::CH_W-1:0] in_index_bottom_right,
  input  logic [pncs_pkg::CH_W-1:0] in_index_bottom_left,
  output logic [pncs_pkg::CH_W-1:0] out_nearest_index
);
  import pncs_pkg::*;

  localparam int IDX_W = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(PALETTE_ENTRIES - 1);
  localparam logic [CH_W:0]    ENTRIES_EXT = (CH_W + 1)'(PALETTE_ENTRIES);
  localparam logic [AVG_K_W-1:0] AVG_LAST  = AVG_K_W'(AVG_TAPS - 1);

  function automatic logic [CH_W-1:0] absdiff(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
    absdiff = (a > b) ? (a - b) : (b - a);
  endfunction

  logic [PAL_W-1:0]   mem_r [PALETTE_ENTRIES];
  logic [CH_W-1:0]    avg_idx_r [AVG_TAPS];
  logic [AVG_K_W-1:0] avg_k_r;
  logic [IDX_W-1:0]   cnt_r;

  logic [CH_W-1:0]    qry_r_r, qry_g_r, qry_b_r;
  logic [SUM_W-1:0]   acc_r_r, acc_g_r, acc_b_r;

  logic [PAL_W-1:0]   rd_data_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic               rd_ok_r, rd_vld_r, rd_scan_r;

  logic [DIST_W-1:0]  dist_r, best_dist_r;
  logic [IDX_W-1:0]   dist_idx_r, best_idx_r, res_r;
  logic               dist_vld_r;

  logic               ld_ok, avg_ok, rd_en;
  logic [CH_W-1:0]    avg_sel;
  logic [IDX_W-1:0]   rd_addr;
  logic [CH_W-1:0]    d_r, d_g, d_b;

  assign ld_ok   = {1'b0, in_entry_index} < ENTRIES_EXT;
  assign avg_sel = avg_idx_r[avg_k_r];
  assign avg_ok  = {1'b0, avg_sel} < ENTRIES_EXT;
  assign rd_en   = cmd.scan_rd | cmd.avg_rd;
  assign rd_addr = cmd.scan_rd ? cnt_r : avg_sel[IDX_W-1:0];

  // Palette memory: one write port from load transfers, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.wr_en && ld_ok) begin
      mem_r[in_entry_index[IDX_W-1:0]] <= {in_red, in_green, in_blue};
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
      rd_idx_r  <= rd_addr;
      rd_ok_r   <= cmd.scan_rd | avg_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r   <= 1'b0;
      rd_scan_r  <= 1'b0;
      dist_vld_r <= 1'b0;
    end else begin
      rd_vld_r   <= rd_en;
      rd_scan_r  <= cmd.scan_rd;
      dist_vld_r <= rd_vld_r & rd_scan_r;
    end
  end

  assign d_r = absdiff(qry_r_r, rd_data_r[3*CH_W-1:2*CH_W]);
  assign d_g = absdiff(qry_g_r, rd_data_r[2*CH_W-1:CH_W]);
  assign d_b = absdiff(qry_b_r, rd_data_r[CH_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      avg_idx_r[0] <= in_index_top_left;
      avg_idx_r[1] <= in_index_top_right;
      avg_idx_r[2] <= in_index_bottom_right;
      avg_idx_r[3] <= in_index_bottom_left;
      avg_k_r      <= '0;
      cnt_r        <= '0;
      qry_r_r      <= in_red;
      qry_g_r      <= in_green;
      qry_b_r      <= in_blue;
      acc_r_r      <= '0;
      acc_g_r      <= '0;
      acc_b_r      <= '0;
      best_dist_r  <= '1;
    end else begin
      if (cmd.avg_rd) begin
        avg_k_r <= avg_k_r + 1'b1;
      end
      if (cmd.scan_rd) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (rd_vld_r && !rd_scan_r && rd_ok_r) begin
        acc_r_r <= acc_r_r + SUM_W'(rd_data_r[3*CH_W-1:2*CH_W]);
        acc_g_r <= acc_g_r + SUM_W'(rd_data_r[2*CH_W-1:CH_W]);
        acc_b_r <= acc_b_r + SUM_W'(rd_data_r[CH_W-1:0]);
      end
      if (cmd.avg_commit) begin
        qry_r_r <= acc_r_r[SUM_W-1:2];
        qry_g_r <= acc_g_r[SUM_W-1:2];
        qry_b_r <= acc_b_r[SUM_W-1:2];
      end
      if (dist_vld_r && (dist_r < best_dist_r)) begin
        best_dist_r <= dist_r;
        best_idx_r  <= dist_idx_r;
      end
    end
    if (rd_vld_r && rd_scan_r) begin
      dist_r     <= DIST_W'(d_r) + DIST_W'(d_g) + DIST_W'(d_b);
      dist_idx_r <= rd_idx_r;
    end
    if (cmd.out_load) begin
      res_r <= best_idx_r;
    end
  end

  assign sts.cnt_last  = (cnt_r == LAST_IDX);
  assign sts.avg_last  = (avg_k_r == AVG_LAST);
  assign sts.pipe_idle = ~rd_vld_r & ~dist_vld_r;

  assign out_nearest_index = CH_W'(res_r);

endmodule

>>> hdl/pncs_ctrl.sv
// Controller: sequences load, average and scan steps and owns the handshakes.
module pncs_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pncs_pkg::CMD_W-1:0] in_cmd,
  output logic                       out_valid,
  input  logic                       out_ready,
  output pncs_pkg::ctrl_cmd_t        cmd,
  input  pncs_pkg::ctrl_sts_t        sts
);
  import pncs_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_AVG,
    ST_AVG_WAIT,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   in_xfer;

  assign in_ready = (state_r == ST_IDLE);
  assign in_xfer  = in_valid & in_ready;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          case (in_cmd)
            CMD_LOAD: cmd.wr_en = 1'b1;
            CMD_FIND: begin
              cmd.capture = 1'b1;
              state_nxt   = ST_SCAN;
            end
            CMD_AVG: begin
              cmd.capture = 1'b1;
              state_nxt   = ST_AVG;
            end
            default: ;
          endcase
        end
      end
      ST_AVG: begin
        cmd.avg_rd = 1'b1;
        if (sts.avg_last) state_nxt = ST_AVG_WAIT;
      end
      ST_AVG_WAIT: begin
        if (sts.pipe_idle) begin
          cmd.avg_commit = 1'b1;
          state_nxt      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_rd = 1'b1;
        if (sts.cnt_last) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (sts.pipe_idle && (!out_valid_r || out_ready)) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_load_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.pipe_idle)
    else $error("result loaded while distance pipeline still busy");

  a_one_read_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.scan_rd && cmd.avg_rd))
    else $error("scan and average reads issued together");

  a_find_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_cmd == CMD_FIND) |=> state_r == ST_SCAN)
    else $error("find transfer did not start a scan");

  a_result_not_overwritten: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

endmodule

>>> hdl/palette_nearest_color_search.sv
// Top level of the palette nearest-color search block.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command per transfer:
//     load  - writes {red, green, blue} into palette entry in_entry_index; an index
//             at or above PALETTE_ENTRIES is dropped. The controller stays idle.
//     find  - searches the palette for the entry with the smallest sum of absolute
//             channel differences to {red, green, blue}; the lowest index wins ties.
//     avg   - reads the four corner indices, sums each channel, shifts right by two
//             and searches that color. An index out of range contributes black.
//   Result channel (out_valid/out_ready) carries out_nearest_index, one per query.
//   Every entry must be loaded before a query scans it; the palette has no reset.
// Timing:
//   A find scans every palette entry from index 0 upward; an average first reads the
//   four corner entries and then scans. The scan reads one palette entry per
//   cycle from a single memory read port, which sets the rate.
//   in_ready is high only while the controller is idle; a query may be accepted
//   while the previous result still waits in the output register. If the receiver
//   stalls, the next result holds in the drain step until that register frees up.
//   Reset (synchronous, rst_n low) returns the controller to idle and empties the
//   output register; palette contents are kept.
module palette_nearest_color_search #(
  parameter int PALETTE_ENTRIES = pncs_pkg::ENTRIES_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [pncs_pkg::CMD_W-1:0] in_cmd,
  input  logic [pncs_pkg::CH_W-1:0]  in_entry_index,
  input  logic [pncs_pkg::CH_W-1:0]  in_red,
  input  logic [pncs_pkg::CH_W-1:0]  in_green,
  input  logic [pncs_pkg::CH_W-1:0]  in_blue,
  input  logic [pncs_pkg::CH_W-1:0]  in_index_top_left,
  input  logic [pncs_pkg::CH_W-1:0]  in_index_top_right,
  input  logic [pncs_pkg::CH_W-1:0]  in_index_bottom_right,
  input  logic [pncs_pkg::CH_W-1:0]  in_index_bottom_left,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [pncs_pkg::CH_W-1:0]  out_nearest_index
);
  import pncs_pkg::*;

  // Command and status bundles between controller and datapath.
  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  pncs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_cmd    (in_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // Palette memory, averaging and the scan pipeline live here.
  pncs_dp #(
    .PALETTE_ENTRIES (PALETTE_ENTRIES)
  ) u_dp (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_entry_index        (in_entry_index),
    .in_red                (in_red),
    .in_green              (in_green),
    .in_blue               (in_blue),
    .in_index_top_left     (in_index_top_left),
    .in_index_top_right    (in_index_top_right),
    .in_index_bottom_right (in_index_bottom_right),
    .in_index_bottom_left  (in_index_bottom_left),
    .out_nearest_index     (out_nearest_index)
  );

endmodule
